[hdl/hpb62_pkg.sv]
// Shared types and constants of the hash prefix base-62 encoder.
// Holds the word structs, the job struct, the back-end state type and the alphabet.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package hpb62_pkg;

  localparam int LEN_W         = 5;
  localparam int DIGIT_W       = 6;
  localparam int CHAR_W        = 7;
  localparam int HALF_W        = 64;
  localparam int NUM_W         = 128;
  localparam int CHUNK_W       = 16;
  localparam int PART_W        = DIGIT_W + CHUNK_W;
  localparam int MAX_DIGITS    = 22;
  localparam int SHORT_LEN_MAX = 10;
  localparam int LEN_RESET     = 8;

  // Reciprocal of 62 scaled by 2^RECIP_SHIFT, rounded up; exact for any 22-bit part
  localparam int RECIP_W     = 23;
  localparam int RECIP_SHIFT = 28;
  localparam logic [RECIP_W-1:0] RECIP_62 = 23'd4329605;
  localparam int PROD_W = PART_W + RECIP_W;

  // First chunk of a digit step: full 128-bit number or low 64 bits only
  localparam logic [2:0] CHUNK_FIRST_WIDE  = 3'd0;
  localparam logic [2:0] CHUNK_FIRST_SHORT = 3'd4;
  localparam logic [2:0] CHUNK_LAST        = 3'd7;

  typedef struct packed {
    logic [HALF_W-1:0] prefix_high;
    logic [HALF_W-1:0] prefix_low;
  } in_word_t;

  typedef struct packed {
    logic [CHAR_W-1:0] out_char;
    logic              char_last;
  } out_word_t;

  typedef struct packed {
    logic [NUM_W-1:0] number;
    logic [LEN_W-1:0] len;
    logic             wide;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIVIDE,
    BK_EMIT
  } back_state_t;

  // Map a digit value to its ASCII character: 0-9, A-Z, a-z
  function automatic logic [CHAR_W-1:0] b62_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < 6'd10) begin
      c = 7'd48 + CHAR_W'(d);
    end else if (d < 6'd36) begin
      c = 7'd55 + CHAR_W'(d);
    end else if (d < 6'd62) begin
      c = 7'd61 + CHAR_W'(d);
    end else begin
      c = 7'd48;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[hdl/hpb62_front.sv]
// Front end: holds the length register, accepts words and turns them into jobs.
// Clamps the length and picks the 64-bit or 128-bit number. Depends on hpb62_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hpb62_front (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [hpb62_pkg::LEN_W-1:0] cfg_data,
  input  wire logic                      start,
  input  wire hpb62_pkg::in_word_t       prefix,
  input  wire logic                      full,
  output logic                           busy,
  output logic                           push,
  output hpb62_pkg::job_t                job
);
  import hpb62_pkg::*;

  logic [LEN_W-1:0] output_length;
  logic [LEN_W-1:0] len_eff;
  logic             wide;

  // Length register, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      output_length <= LEN_W'(LEN_RESET);
    end else if (cfg_valid && cfg_ready) begin
      output_length <= cfg_data;
    end
  end

  // Clamp the length to 1..22 and choose the number width
  always_comb begin
    if (output_length == '0) begin
      len_eff = LEN_W'(1);
    end else if (output_length > LEN_W'(MAX_DIGITS)) begin
      len_eff = LEN_W'(MAX_DIGITS);
    end else begin
      len_eff = output_length;
    end
    wide = (len_eff > LEN_W'(SHORT_LEN_MAX));
  end

  // Accept while the queue has room
  assign busy = full;
  assign push = start && !full;

  always_comb begin
    job.len  = len_eff;
    job.wide = wide;
    if (wide) begin
      job.number = {prefix.prefix_high, prefix.prefix_low};
    end else begin
      job.number = {{HALF_W{1'b0}}, prefix.prefix_high};
    end
  end

endmodule

`default_nettype wire

[hdl/hpb62_fifo.sv]
// Short job queue between front end and back end.
// Register array with read and write pointers. Depends on hpb62_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hpb62_fifo #(
  parameter int DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  wire hpb62_pkg::job_t wr_job,
  output logic             full,
  input  wire logic        pop,
  output hpb62_pkg::job_t  rd_job,
  output logic             empty
);
  import hpb62_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full   = (count == CNT_W'(DEPTH));
  assign empty  = (count == '0);
  assign rd_job = slots[rd_ptr];

  // Store incoming jobs
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  // Advance pointers and track fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

[hdl/hpb62_back.sv]
// Back end: divides the job number by 62 one 16-bit chunk per cycle,
// stores the remainders as digits, then emits characters one per cycle.
// Depends on hpb62_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hpb62_back (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        empty,
  input  wire hpb62_pkg::job_t job,
  output logic             pop,
  output logic             result_valid,
  output hpb62_pkg::out_word_t result
);
  import hpb62_pkg::*;

  back_state_t state;
  back_state_t state_next;

  logic [NUM_W-1:0]   num;
  logic [DIGIT_W-1:0] r;
  logic [2:0]         chunk;
  logic               wide;
  logic [LEN_W-1:0]   len;
  logic [LEN_W-1:0]   dcount;
  logic [LEN_W-1:0]   idx;
  logic [LEN_W-1:0]   left;
  logic [DIGIT_W-1:0] digit_store [MAX_DIGITS];

  logic [2:0]         first_chunk;
  logic [6:0]         chunk_lsb;
  logic [CHUNK_W-1:0] chunk_val;
  logic [PART_W-1:0]  part;
  logic [PROD_W-1:0]  prod;
  logic [CHUNK_W-1:0] quo;
  logic [PART_W-1:0]  quo62;
  logic [PART_W-1:0]  rem_full;
  logic [DIGIT_W-1:0] rem;
  logic               at_start;
  logic               finished;
  logic [LEN_W-1:0]   top;
  logic [DIGIT_W-1:0] digit;

  // One chunk of the long division by 62, most significant chunk first
  assign first_chunk = wide ? CHUNK_FIRST_WIDE : CHUNK_FIRST_SHORT;
  assign chunk_lsb   = {~chunk, 4'b0000};
  assign chunk_val   = num[chunk_lsb +: CHUNK_W];
  assign part        = {r, chunk_val};
  assign prod        = PROD_W'(part) * PROD_W'(RECIP_62);
  assign quo         = prod[RECIP_SHIFT +: CHUNK_W];
  assign quo62       = {quo, 6'b000000} - {5'b00000, quo, 1'b0};
  assign rem_full    = part - quo62;
  assign rem         = rem_full[DIGIT_W-1:0];

  // Stop at a digit boundary once the quotient is zero or the store is full
  assign at_start = (chunk == first_chunk);
  assign finished = at_start && ((num == '0) || (dcount == LEN_W'(MAX_DIGITS)));
  assign top      = (dcount > len) ? dcount : len;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (!empty) state_next = BK_DIVIDE;
      end
      BK_DIVIDE: begin
        if (finished) state_next = BK_EMIT;
      end
      BK_EMIT: begin
        if (left == '0) state_next = BK_IDLE;
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    digit = (idx < dcount) ? digit_store[idx] : '0;
    pop          = 1'b0;
    result_valid = 1'b0;
    unique case (state)
      BK_IDLE:   pop = !empty;
      BK_DIVIDE: pop = 1'b0;
      BK_EMIT:   result_valid = 1'b1;
      default:   pop = 1'b0;
    endcase
    result.out_char  = b62_char(digit);
    result.char_last = (left == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath: load, divide, emit
  always_ff @(posedge clk) begin
    if (rst) begin
      dcount <= '0;
    end else begin
      case (state)
        BK_IDLE: begin
          if (!empty) begin
            num    <= job.number;
            len    <= job.len;
            wide   <= job.wide;
            chunk  <= job.wide ? CHUNK_FIRST_WIDE : CHUNK_FIRST_SHORT;
            r      <= '0;
            dcount <= '0;
          end
        end
        BK_DIVIDE: begin
          if (finished) begin
            idx  <= top - LEN_W'(1);
            left <= len - LEN_W'(1);
          end else begin
            num[chunk_lsb +: CHUNK_W] <= quo;
            if (chunk == CHUNK_LAST) begin
              digit_store[dcount] <= rem;
              dcount <= dcount + LEN_W'(1);
              chunk  <= first_chunk;
              r      <= '0;
            end else begin
              chunk <= chunk + 3'd1;
              r     <= rem;
            end
          end
        end
        BK_EMIT: begin
          idx  <= idx - LEN_W'(1);
          left <= left - LEN_W'(1);
        end
        default: begin
          dcount <= '0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[hdl/hash_prefix_base62_encoder.sv]
// Top level of the hash prefix base-62 encoder.
// Ties front end, job queue and back end together. Depends on hpb62_pkg,
// hpb62_front, hpb62_fifo and hpb62_back.
//
// Use:
//   Write the output length (1..22, 0 reads as 1, above 22 as 22) on the
//   cfg channel; it is taken on any cycle with cfg_valid high (cfg_ready is
//   always high). Reset sets it to 8.
//   Present a digest prefix on prefix and raise start; the word is taken
//   when start is high and busy is low. busy is high only when the job
//   queue (QUEUE_DEPTH entries) is full.
//   Each character appears on result for one cycle with result_valid high;
//   char_last marks the last character of a word. The receiver cannot stall.
// Timing:
//   Digits come from a 16-bit-chunk divide by 62, one chunk per cycle: 4
//   chunks per digit for lengths up to 10 (64-bit number), 8 for longer
//   lengths (128-bit number). The back end works on one word at a time: it
//   divides out its D digits (D at most 11 or 22), then emits L characters
//   for length L. Reset empties the queue and idles the back end.
`timescale 1ns / 1ps
`default_nettype none

module hash_prefix_base62_encoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [hpb62_pkg::LEN_W-1:0] cfg_data,
  input  wire logic                        start,
  output logic                             busy,
  input  wire hpb62_pkg::in_word_t         prefix,
  output logic                             result_valid,
  output hpb62_pkg::out_word_t             result
);
  import hpb62_pkg::*;

  job_t front_job;
  job_t back_job;
  logic push;
  logic pop;
  logic full;
  logic empty;

  // Accept and classify words
  hpb62_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .start     (start),
    .prefix    (prefix),
    .full      (full),
    .busy      (busy),
    .push      (push),
    .job       (front_job)
  );

  // Hold pending jobs
  hpb62_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_job (front_job),
    .full   (full),
    .pop    (pop),
    .rd_job (back_job),
    .empty  (empty)
  );

  // Divide and emit characters
  hpb62_back u_back (
    .clk          (clk),
    .rst          (rst),
    .empty        (empty),
    .job          (back_job),
    .pop          (pop),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

`default_nettype wire
